[src/biou_pkg.sv]
`default_nettype none

package biou_pkg;

  localparam int CoordW = 16;
  // Double-scale axis overlap never exceeds twice the smaller size.
  localparam int OvW    = 17;
  localparam int AreaW  = 2 * CoordW;
  localparam int InterW = 2 * OvW;
  // Four times the sum of both areas.
  localparam int UnionW = AreaW + 3;
  localparam int RemW   = UnionW + 1;
  localparam int IouW   = 17;
  localparam int NumCells = IouW;
  // Input register, product stage, union stage, the cells, output register.
  localparam int Latency = NumCells + 4;
  localparam logic [IouW-1:0] IouOne = IouW'(1) << (IouW - 1);

  typedef struct packed {
    logic [CoordW-1:0] a_x;
    logic [CoordW-1:0] a_y;
    logic [CoordW-1:0] a_w;
    logic [CoordW-1:0] a_h;
    logic [CoordW-1:0] b_x;
    logic [CoordW-1:0] b_y;
    logic [CoordW-1:0] b_w;
    logic [CoordW-1:0] b_h;
  } biou_in_t;

  typedef struct packed {
    logic [IouW-1:0] iou;
    logic            empty_union;
  } biou_out_t;

  // What travels from one divider cell to the next.
  typedef struct packed {
    logic              vld;
    logic [RemW-1:0]   rem;
    logic [UnionW-1:0] den;
    logic [IouW-1:0]   quo;
    logic              empty;
  } biou_cell_t;

endpackage

`default_nettype wire

[src/biou_front.sv]
`default_nettype none

module biou_front
  import biou_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_vld,
  input  wire biou_in_t   in_box,
  output biou_cell_t      cell_out
);

  function automatic logic [OvW-1:0] axis_ov(input logic [CoordW-1:0] c1,
                                             input logic [CoordW-1:0] s1,
                                             input logic [CoordW-1:0] c2,
                                             input logic [CoordW-1:0] s2);
    logic signed [19:0] l1;
    logic signed [19:0] l2;
    logic signed [19:0] r1;
    logic signed [19:0] r2;
    logic signed [19:0] lmax;
    logic signed [19:0] rmin;
    logic signed [19:0] ov;
    l1 = $signed({3'b000, c1, 1'b0}) - $signed({4'b0000, s1});
    l2 = $signed({3'b000, c2, 1'b0}) - $signed({4'b0000, s2});
    r1 = $signed({3'b000, c1, 1'b0}) + $signed({4'b0000, s1});
    r2 = $signed({3'b000, c2, 1'b0}) + $signed({4'b0000, s2});
    lmax = (l1 > l2) ? l1 : l2;
    rmin = (r1 < r2) ? r1 : r2;
    ov = rmin - lmax;
    // A non-positive overlap on one axis zeroes the product downstream.
    return (ov > 20'sd0) ? ov[OvW-1:0] : '0;
  endfunction

  logic              vld1_r, vld1_nxt;
  logic [OvW-1:0]    ow1_r, ow1_nxt;
  logic [OvW-1:0]    oh1_r, oh1_nxt;
  logic [CoordW-1:0] aw1_r, ah1_r, bw1_r, bh1_r;

  logic              vld2_r;
  logic [InterW-1:0] inter2_r, inter2_nxt;
  logic [AreaW-1:0]  areaa2_r, areaa2_nxt;
  logic [AreaW-1:0]  areab2_r, areab2_nxt;

  biou_cell_t        cell_r, cell_nxt;
  logic [UnionW-1:0] sum4;

  always_comb begin
    vld1_nxt = in_vld;
    ow1_nxt  = axis_ov(in_box.a_x, in_box.a_w, in_box.b_x, in_box.b_w);
    oh1_nxt  = axis_ov(in_box.a_y, in_box.a_h, in_box.b_y, in_box.b_h);
  end

  always_comb begin
    inter2_nxt = ow1_r * oh1_r;
    areaa2_nxt = aw1_r * ah1_r;
    areab2_nxt = bw1_r * bh1_r;
  end

  always_comb begin
    sum4 = {1'b0, areaa2_r, 2'b00} + {1'b0, areab2_r, 2'b00};
    cell_nxt.vld = vld2_r;
    cell_nxt.den = (sum4 >= UnionW'(inter2_r)) ? (sum4 - UnionW'(inter2_r)) : '0;
    cell_nxt.rem = RemW'(inter2_r);
    cell_nxt.quo = '0;
    cell_nxt.empty = (cell_nxt.den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      cell_r.vld <= 1'b0;
    end else begin
      vld1_r     <= vld1_nxt;
      vld2_r     <= vld1_r;
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.rem   <= cell_nxt.rem;
    cell_r.den   <= cell_nxt.den;
    cell_r.quo   <= cell_nxt.quo;
    cell_r.empty <= cell_nxt.empty;
  end

  always_ff @(posedge clk) begin
    ow1_r        <= ow1_nxt;
    oh1_r        <= oh1_nxt;
    aw1_r        <= in_box.a_w;
    ah1_r        <= in_box.a_h;
    bw1_r        <= in_box.b_w;
    bh1_r        <= in_box.b_h;
    inter2_r     <= inter2_nxt;
    areaa2_r     <= areaa2_nxt;
    areab2_r     <= areab2_nxt;
  end

  assign cell_out = cell_r;

endmodule

`default_nettype wire

[src/biou_div_cell.sv]
`default_nettype none

module biou_div_cell
  import biou_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire biou_cell_t cell_in,
  output biou_cell_t      cell_out
);

  biou_cell_t      cell_r, cell_nxt;
  logic            ge;
  logic [RemW-1:0] rem_sel;

  // One restoring step: the remainder entering is always below twice the divisor.
  always_comb begin
    ge       = (cell_in.rem >= RemW'(cell_in.den));
    rem_sel  = ge ? (cell_in.rem - RemW'(cell_in.den)) : cell_in.rem;
    cell_nxt = cell_in;
    cell_nxt.rem = {rem_sel[RemW-2:0], 1'b0};
    cell_nxt.quo = {cell_in.quo[IouW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.rem   <= cell_nxt.rem;
    cell_r.den   <= cell_nxt.den;
    cell_r.quo   <= cell_nxt.quo;
    cell_r.empty <= cell_nxt.empty;
  end

  assign cell_out = cell_r;

endmodule

`default_nettype wire

[src/box_iou_ratio.sv]
// Intersection over union of two boxes given by center and size.
// A request carries both boxes (in_box) and is taken at each clock edge where
// start is high; busy stays low, so a new pair may be issued every cycle.
// Each request produces exactly one result on out_res, shown for a single
// cycle with out_valid high. Results come out in request order.
// A request passes, in order, an input register with the edge and overlap
// logic, a product stage for the three areas, a stage that forms the union,
// one divider cell per quotient bit (17 cells, each a 36-bit compare and
// subtract), and the output register. Throughput is one pair per cycle.
// iou is floor(intersection * 65536 / union), where 65536 means 1.0. When
// the union area is zero, iou is 0 and empty_union is set.
// Synchronous reset clears all valid bits, so requests in flight are dropped
// and out_valid is low until a new request has passed the pipeline.
// The receiver cannot stall; it must take each result in its cycle.
`default_nettype none

module box_iou_ratio
  import biou_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire biou_in_t in_box,
  output logic          out_valid,
  output biou_out_t     out_res
);

  biou_cell_t chain [NumCells+1];

  logic       out_valid_r, out_valid_nxt;
  biou_out_t  out_res_r, out_res_nxt;

  assign busy = 1'b0;

  biou_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_box   (in_box),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    biou_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  always_comb begin
    out_valid_nxt = chain[NumCells].vld;
    out_res_nxt.empty_union = chain[NumCells].empty;
    if (chain[NumCells].empty) begin
      out_res_nxt.iou = '0;
    end else if (chain[NumCells].quo > IouOne) begin
      out_res_nxt.iou = IouOne;
    end else begin
      out_res_nxt.iou = chain[NumCells].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result appeared without a matching request");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.empty_union) |-> (out_res.iou == '0))
    else $error("empty union with nonzero iou");

endmodule

`default_nettype wire
